### rtl/core/assert_macros.svh
// assertion macros used by the allocator top level
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

### rtl/core/bba_pkg.sv
// types, constants and helpers of the buddy block allocator
// no dependencies
`timescale 1ns / 1ps

package bba_pkg;

  localparam int LEVELS     = 10;
  localparam int NODE_COUNT = (2 << LEVELS) - 1;
  localparam int LEAF_BASE  = (1 << LEVELS) - 1;
  localparam int NODE_W     = LEVELS + 1;
  localparam int LVL_W      = $clog2(LEVELS + 1);
  localparam int H_W        = LVL_W + 1;
  localparam int BS_W       = 4;
  localparam int REQ_W      = 23;
  localparam int OFF_W      = 22;
  localparam int BS_RESET   = 6;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LVL_W-1:0] lvl_t;
  typedef logic signed [H_W-1:0] height_t;

  // allocated mark, ranks below every height
  localparam height_t TAKEN = '1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_ZERO_SIZE   = 2'd2,
    ST_BAD_RELEASE = 2'd3
  } status_t;

  typedef struct packed {
    logic              action;
    logic [REQ_W-1:0]  request_bytes;
    logic [OFF_W-1:0]  release_offset;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [OFF_W-1:0]  granted_offset;
  } out_word_t;

  typedef struct packed {
    logic    we;
    node_t   waddr;
    height_t wdata;
    node_t   raddr;
  } mem_req_t;

  function automatic height_t lvl_height(lvl_t l);
    return height_t'({1'b0, l});
  endfunction

  // height of a node straight after reset
  function automatic height_t reset_height(node_t n);
    node_t p;
    lvl_t  d;
    p = n + 1'b1;
    d = '0;
    for (int i = 0; i < NODE_W; i++) begin
      if (p[i]) begin
        d = LVL_W'(i);
      end
    end
    return lvl_height(LVL_W'(LEVELS) - d);
  endfunction

endpackage

### rtl/core/bba_tree_ram.sv
// node memory of the allocator tree, one write and one registered read port
// depends on bba_pkg
`timescale 1ns / 1ps

module bba_tree_ram (
  input  logic              clk,
  input  bba_pkg::mem_req_t mem_req,
  output bba_pkg::height_t  rd_data
);
  import bba_pkg::*;

  height_t mem [NODE_COUNT];
  height_t rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rd_data_r <= mem[mem_req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/bba_ctrl.sv
// sequencer of the allocator: memory sweep, sizing, tree descent, climb and rebuild
// depends on bba_pkg, drives bba_tree_ram
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  bba_pkg::in_word_t            in_word,
  input  logic [bba_pkg::BS_W-1:0]     block_shift,
  output logic                         out_valid,
  output bba_pkg::out_word_t           out_word,
  output bba_pkg::mem_req_t            mem_req,
  input  bba_pkg::height_t             rd_data
);
  import bba_pkg::*;

  localparam int BLK_W = REQ_W + 1;
  localparam int SH_W  = LEVELS + (1 << BS_W) - 1;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_SIZE  = 8'b0000_0100,
    S_WANT  = 8'b0000_1000,
    S_DOWN  = 8'b0001_0000,
    S_UP    = 8'b0010_0000,
    S_RCHK  = 8'b0100_0000,
    S_CLIMB = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  node_t               node_r, node_nxt;
  lvl_t                lvl_r, lvl_nxt;
  height_t             cur_r, cur_nxt;
  lvl_t                want_r, want_nxt;
  logic                merge_r, merge_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [OFF_W-1:0]    off_r, off_nxt;
  logic [BLK_W-1:0]    blocks_r, blocks_nxt;
  logic [LEVELS-1:0]   blk_r, blk_nxt;
  node_t               clr_r, clr_nxt;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic                fin;
  status_t             fin_status;
  logic [OFF_W-1:0]    fin_off;

  logic [BLK_W-1:0]    mask;
  logic [BLK_W-1:0]    bm1;
  lvl_t                want_c;
  logic                too_big;
  node_t               left_c, child_c, parent_c, span_c;
  lvl_t                lvl_up;
  height_t             up_val;
  logic [OFF_W-1:0]    rel_blk;
  logic [OFF_W-1:0]    grant_off;

  function automatic node_t sibling(node_t n);
    return n[0] ? n + 1'b1 : n - 1'b1;
  endfunction

  always_comb begin
    mask = (BLK_W'(1) << block_shift) - 1'b1;
    bm1  = blocks_r - 1'b1;
    want_c = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (bm1[i]) begin
        want_c = LVL_W'(i + 1);
      end
    end
    too_big  = blocks_r > (BLK_W'(1) << LEVELS);
    left_c   = {node_r[NODE_W-2:0], 1'b1};
    child_c  = (rd_data < lvl_height(want_r)) ? left_c + 1'b1 : left_c;
    span_c   = (child_c + 1'b1) << want_r;
    parent_c = (node_r - 1'b1) >> 1;
    lvl_up   = lvl_r + 1'b1;
    if (merge_r && cur_r == lvl_height(lvl_r) && rd_data == lvl_height(lvl_r)) begin
      up_val = lvl_height(lvl_up);
    end else begin
      up_val = (cur_r > rd_data) ? cur_r : rd_data;
    end
    rel_blk   = off_r >> block_shift;
    grant_off = OFF_W'(SH_W'(blk_r) << block_shift);
  end

  always_comb begin
    state_nxt  = state_r;
    node_nxt   = node_r;
    lvl_nxt    = lvl_r;
    cur_nxt    = cur_r;
    want_nxt   = want_r;
    merge_nxt  = merge_r;
    req_nxt    = req_r;
    off_nxt    = off_r;
    blocks_nxt = blocks_r;
    blk_nxt    = blk_r;
    clr_nxt    = clr_r;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_off    = '0;
    mem_req.we    = 1'b0;
    mem_req.waddr = '0;
    mem_req.wdata = '0;
    mem_req.raddr = '0;

    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
        mem_req.wdata = reset_height(clr_r);
        clr_nxt       = clr_r + 1'b1;
        if (clr_r == NODE_W'(NODE_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_word.request_bytes;
          off_nxt   = in_word.release_offset;
          state_nxt = (in_word.action == ACT_RELEASE) ? S_RCHK : S_SIZE;
        end
      end
      S_SIZE: begin
        // root is read here for the room check
        blocks_nxt = (BLK_W'(req_r) + mask) >> block_shift;
        if (req_r == '0) begin
          fin        = 1'b1;
          fin_status = ST_ZERO_SIZE;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_WANT;
        end
      end
      S_WANT: begin
        want_nxt = want_c;
        if (too_big || rd_data < lvl_height(want_c)) begin
          fin        = 1'b1;
          fin_status = ST_NO_SPACE;
          state_nxt  = S_IDLE;
        end else if (want_c == LVL_W'(LEVELS)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = TAKEN;
          fin           = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          node_nxt      = '0;
          lvl_nxt       = LVL_W'(LEVELS);
          mem_req.raddr = NODE_W'(1);
          state_nxt     = S_DOWN;
        end
      end
      S_DOWN: begin
        node_nxt = child_c;
        lvl_nxt  = lvl_r - 1'b1;
        if (lvl_r - 1'b1 == want_r) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = child_c;
          mem_req.wdata = TAKEN;
          mem_req.raddr = sibling(child_c);
          cur_nxt       = TAKEN;
          merge_nxt     = 1'b0;
          blk_nxt       = LEVELS'(span_c - NODE_W'(1 << LEVELS));
          state_nxt     = S_UP;
        end else begin
          mem_req.raddr = {child_c[NODE_W-2:0], 1'b1};
        end
      end
      S_UP: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = parent_c;
        mem_req.wdata = up_val;
        node_nxt      = parent_c;
        lvl_nxt       = lvl_up;
        cur_nxt       = up_val;
        if (parent_c == '0) begin
          fin       = 1'b1;
          fin_off   = merge_r ? '0 : grant_off;
          state_nxt = S_IDLE;
        end else begin
          mem_req.raddr = sibling(parent_c);
        end
      end
      S_RCHK: begin
        if (rel_blk >= OFF_W'(1 << LEVELS)) begin
          fin        = 1'b1;
          fin_status = ST_BAD_RELEASE;
          state_nxt  = S_IDLE;
        end else begin
          node_nxt      = NODE_W'(rel_blk[LEVELS-1:0]) + NODE_W'(LEAF_BASE);
          mem_req.raddr = NODE_W'(rel_blk[LEVELS-1:0]) + NODE_W'(LEAF_BASE);
          lvl_nxt       = '0;
          state_nxt     = S_CLIMB;
        end
      end
      S_CLIMB: begin
        if (rd_data == TAKEN) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = node_r;
          mem_req.wdata = lvl_height(lvl_r);
          cur_nxt       = lvl_height(lvl_r);
          merge_nxt     = 1'b1;
          if (node_r == '0) begin
            fin       = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            mem_req.raddr = sibling(node_r);
            state_nxt     = S_UP;
          end
        end else if (node_r == '0) begin
          fin        = 1'b1;
          fin_status = ST_BAD_RELEASE;
          state_nxt  = S_IDLE;
        end else begin
          node_nxt      = parent_c;
          lvl_nxt       = lvl_up;
          mem_req.raddr = parent_c;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    node_r   <= node_nxt;
    lvl_r    <= lvl_nxt;
    cur_r    <= cur_nxt;
    want_r   <= want_nxt;
    merge_r  <= merge_nxt;
    req_r    <= req_nxt;
    off_r    <= off_nxt;
    blocks_r <= blocks_nxt;
    blk_r    <= blk_nxt;
    if (fin) begin
      out_word_r.status         <= fin_status;
      out_word_r.granted_offset <= fin_off;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

### rtl/core/buddy_block_allocator.sv
// top level of the buddy block allocator: apb register, sequencer, node memory
// depends on bba_pkg, bba_ctrl, bba_tree_ram and assert_macros.svh
//
// a pool of 2^LEVELS blocks of 2^block_shift bytes, kept as a binary tree of
// largest-free-run heights in one synchronous node memory.
// command channel: a word on in_word is taken at a clock edge with start high
// and busy low; action selects allocate or release.
// result channel: one word per command on out_word, marked by out_valid for a
// single cycle; there is no back-pressure, the receiver must take it.
// an allocate sizes the request, checks the root for room, descends to the
// wanted level and rebuilds the heights up to the root; a release climbs from
// the leaf of the offset to the allocated node and rebuilds up to the root.
// zero size and no space end before the descent; an offset outside the pool
// or a release of free memory gives a bad release status.
// busy drops in the strobe cycle and its closing edge may take the next
// command; in an allocation each tree level costs one read down and one up.
// after reset all 2047 nodes of the node memory are swept, one node per cycle,
// with busy high; block_shift (reset 6) is written through the apb port; the
// user writes it only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module buddy_block_allocator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  bba_pkg::in_word_t   in_word,
  output logic                out_valid,
  output bba_pkg::out_word_t  out_word,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bba_pkg::*;

  localparam logic ADDR_BLOCK_SHIFT = 1'b0;

  logic [BS_W-1:0] block_shift_r, block_shift_nxt;
  logic            cfg_wr;
  mem_req_t        mem_req;
  height_t         rd_data;

  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    block_shift_nxt = block_shift_r;
    if (cfg_wr && paddr[2] == ADDR_BLOCK_SHIFT) begin
      block_shift_nxt = pwdata[BS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_shift_r <= BS_W'(BS_RESET);
    end else begin
      block_shift_r <= block_shift_nxt;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == ADDR_BLOCK_SHIFT) ? 32'(block_shift_r) : '0;

  bba_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_word     (in_word),
    .block_shift (block_shift_r),
    .out_valid   (out_valid),
    .out_word    (out_word),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

  bba_tree_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  `BBA_ASSERT_IMP(a_result_after_work, out_valid, $past(busy))
  `BBA_ASSERT_NEXT(a_no_result_after_accept, start && !busy, !out_valid && busy)
  `BBA_ASSERT_IMP(a_offset_zero_on_error, out_valid && out_word.status != ST_OK,
                  out_word.granted_offset == '0)
  `BBA_ASSERT_IMP(a_no_write_when_idle, !busy, !mem_req.we)

endmodule
